[rtl/adfp_pkg.sv]
// ----------------------------------------------------------------------------
// adfp_pkg: shared types and constants for the ASCII decimal field parser
// Character codes, command and result words, and default sizes.
// ----------------------------------------------------------------------------
package adfp_pkg;

  // Field widths
  localparam int ACC_W  = 50;
  localparam int MANT_W = 51;
  localparam int FRAC_W = 4;
  localparam int POS_W  = 5;
  localparam int DIG_W  = 4;

  // Saturation limits of the counters
  localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;
  localparam logic [POS_W-1:0]  POS_MAX  = 5'd31;

  // Defaults for top-level parameters
  localparam int MAX_CHARS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Character codes
  localparam logic [7:0] CH_PLUS         = 8'h2B;
  localparam logic [7:0] CH_MINUS        = 8'h2D;
  localparam logic [7:0] CH_DOT          = 8'h2E;
  localparam logic [7:0] CH_COMMA        = 8'h2C;
  localparam logic [7:0] CH_BELOW_DIGITS = 8'h2F;
  localparam logic [7:0] CH_ABOVE_DIGITS = 8'h3A;

  // Character classes
  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_DOT,
    CLS_COMMA,
    CLS_PLUS,
    CLS_MINUS,
    CLS_OTHER
  } cls_t;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Classified command word, front to back
  typedef struct packed {
    cls_t             cls;
    logic             first;
    logic [DIG_W-1:0] digit;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic                     status;
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        fraction_digits;
  } res_t;

endpackage

[rtl/adfp_fifo.sv]
// ----------------------------------------------------------------------------
// adfp_fifo: small register queue
// Holds DEPTH words; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module adfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("fifo count beyond depth");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("fifo pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("fifo count did not follow a push");
`endif

endmodule

[rtl/adfp_front.sv]
// ----------------------------------------------------------------------------
// adfp_front: character classifier
// Turns an incoming character into a command word for the back end.
// ----------------------------------------------------------------------------
module adfp_front
  import adfp_pkg::*;
(
  input  logic [7:0] character,
  input  logic       first_char,
  output cmd_t       cmd
);

  // Decode the character class and its digit value
  always_comb begin
    cmd.first = first_char;
    cmd.digit = character[DIG_W-1:0];
    if (character > CH_BELOW_DIGITS && character < CH_ABOVE_DIGITS) begin
      cmd.cls = CLS_DIGIT;
    end else if (character == CH_DOT) begin
      cmd.cls = CLS_DOT;
    end else if (character == CH_COMMA) begin
      cmd.cls = CLS_COMMA;
    end else if (character == CH_PLUS) begin
      cmd.cls = CLS_PLUS;
    end else if (character == CH_MINUS) begin
      cmd.cls = CLS_MINUS;
    end else begin
      cmd.cls = CLS_OTHER;
    end
  end

endmodule

[rtl/adfp_exec.sv]
// ----------------------------------------------------------------------------
// adfp_exec: field accumulator
// Consumes one command word per cycle while the result queue is not full,
// keeps the field state and pushes a result word on comma or error.
// ----------------------------------------------------------------------------
module adfp_exec
  import adfp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHARS);

  // Field state
  logic [ACC_W-1:0]  acc;
  logic [FRAC_W-1:0] frac;
  logic [POS_W-1:0]  pos;
  logic              dot;
  logic              neg;
  logic              active;

  logic [ACC_W-1:0]  acc_next;
  logic [FRAC_W-1:0] frac_next;
  logic [POS_W-1:0]  pos_next;
  logic              dot_next;
  logic              neg_next;
  logic              active_next;

  // State as seen by this word (cleared by a first flag)
  logic [ACC_W-1:0]  acc_b;
  logic [FRAC_W-1:0] frac_b;
  logic [POS_W-1:0]  pos_b;
  logic              dot_b;
  logic              neg_b;
  logic              active_b;

  logic [ACC_W-1:0]  acc_prod;
  logic [POS_W-1:0]  pos_inc;
  logic              limit_hit;
  logic              is_sign;
  logic [MANT_W-1:0] mag;

  assign cmd_pop = cmd_valid && !res_full;

  // Base state and datapath
  always_comb begin
    acc_b     = cmd.first ? '0 : acc;
    frac_b    = cmd.first ? '0 : frac;
    pos_b     = cmd.first ? '0 : pos;
    dot_b     = cmd.first ? 1'b0 : dot;
    neg_b     = cmd.first ? (cmd.cls == CLS_MINUS) : neg;
    active_b  = cmd.first || active;
    is_sign   = cmd.first && (cmd.cls == CLS_PLUS || cmd.cls == CLS_MINUS);
    acc_prod  = (acc_b << 3) + (acc_b << 1) + ACC_W'(cmd.digit);
    pos_inc   = (pos_b < POS_MAX) ? pos_b + 1'b1 : pos_b;
    limit_hit = (pos_inc >= POS_LIMIT);
    mag       = {1'b0, acc_b};
  end

  // Next state and result
  always_comb begin
    acc_next    = acc;
    frac_next   = frac;
    pos_next    = pos;
    dot_next    = dot;
    neg_next    = neg;
    active_next = active;
    res_push    = 1'b0;
    res.status          = STATUS_OK;
    res.mantissa        = '0;
    res.fraction_digits = '0;

    if (cmd_pop) begin
      if (cmd.first) begin
        acc_next    = acc_b;
        frac_next   = frac_b;
        pos_next    = pos_b;
        dot_next    = dot_b;
        neg_next    = neg_b;
        active_next = 1'b1;
      end
      if (active_b && !is_sign) begin
        case (cmd.cls)
          CLS_COMMA: begin
            res_push            = 1'b1;
            res.mantissa        = neg_b ? -mag : mag;
            res.fraction_digits = frac_b;
            active_next         = 1'b0;
          end
          CLS_DIGIT: begin
            acc_next  = acc_prod;
            frac_next = (dot_b && frac_b < FRAC_MAX) ? frac_b + 1'b1 : frac_b;
            pos_next  = pos_inc;
            if (limit_hit) begin
              res_push    = 1'b1;
              res.status  = STATUS_ERR;
              active_next = 1'b0;
            end
          end
          CLS_DOT: begin
            if (dot_b) begin
              res_push    = 1'b1;
              res.status  = STATUS_ERR;
              active_next = 1'b0;
            end else begin
              dot_next = 1'b1;
              pos_next = pos_inc;
              if (limit_hit) begin
                res_push    = 1'b1;
                res.status  = STATUS_ERR;
                active_next = 1'b0;
              end
            end
          end
          default: begin
            // bad character, or a sign past the first position
            res_push    = 1'b1;
            res.status  = STATUS_ERR;
            active_next = 1'b0;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      frac   <= '0;
      pos    <= '0;
      dot    <= 1'b0;
      neg    <= 1'b0;
      active <= 1'b0;
    end else begin
      acc    <= acc_next;
      frac   <= frac_next;
      pos    <= pos_next;
      dot    <= dot_next;
      neg    <= neg_next;
      active <= active_next;
    end
  end

`ifndef ASSERT_OFF
  a_frac_le_pos: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, frac} <= pos))
    else $error("more fraction digits than positions");
  a_active_limit: assert property (@(posedge clk) disable iff (rst)
    active |-> (pos < POS_LIMIT))
    else $error("field still open at the position limit");
  a_result_closes: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !active)
    else $error("field still open after a result");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == STATUS_ERR) |->
      (res.mantissa == '0 && res.fraction_digits == '0))
    else $error("error result carries data");
`endif

endmodule

[rtl/ascii_decimal_field_parser_core.sv]
// ----------------------------------------------------------------------------
// ascii_decimal_field_parser_core: comma-terminated decimal field parser
// Converts ASCII numeric fields into a signed mantissa and fraction count.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive character and first_char with push; a word is taken
//   on a clock edge with push high and full low. first_char restarts the
//   parser on that character.
//   Result queue: while empty is low, status, mantissa and fraction_digits
//   show the oldest result; pop high with empty low takes it. The value is
//   mantissa * 10^-fraction_digits; an error gives status 1 and zeros.
//   Path: the comma (or offending character) is stored in the command
//   queue; when it reaches the head, the accumulator decodes it and the
//   result lands in the result queue.
//   Throughput: one character per cycle while the result queue is not
//   full, set by the single multiply-by-ten and add of the accumulator;
//   the command and result queues each hold QUEUE_DEPTH words.
//   Stall: if pop stays low, the result queue fills, the accumulator stops
//   taking commands, the command queue fills and full rises.
//   Reset: rst clears both queues and puts the parser idle; characters are
//   ignored until one arrives with first_char set.
// ----------------------------------------------------------------------------
module ascii_decimal_field_parser_core
  import adfp_pkg::*;
#(
  parameter int MAX_CHARS   = MAX_CHARS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               character,
  input  logic                     first_char,
  input  logic                     push,
  output logic                     full,
  output logic                     status,
  output logic signed [MANT_W-1:0] mantissa,
  output logic [FRAC_W-1:0]        fraction_digits,
  output logic                     empty,
  input  logic                     pop
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_q;
  logic             cmd_empty;
  logic             cmd_pop;
  res_t             res_in;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_q;
  res_t             res_out;

  // Front end: classify the incoming character
  adfp_front u_front (
    .character (character),
    .first_char(first_char),
    .cmd       (cmd_in)
  );

  // Command queue between front and back
  adfp_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd_q),
    .empty(cmd_empty)
  );

  // Back end: field accumulator
  adfp_exec #(
    .MAX_CHARS(MAX_CHARS)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd_t'(cmd_q)),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue
  adfp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_q),
    .empty(empty)
  );

  assign res_out         = res_t'(res_q);
  assign status          = res_out.status;
  assign mantissa        = res_out.mantissa;
  assign fraction_digits = res_out.fraction_digits;

endmodule
